>>> rtl/rfs_pkg.sv
// ============================================================================
// rfs_pkg
// Shared types, register map and constants of the restriction fragment scanner.
// ============================================================================
package rfs_pkg;

    // Default datapath widths
    localparam int POS_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration address map (word index)
    localparam int                REG_IDX_W    = 3;
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FRAG = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAG = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SITE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CUT      = 3'd4;

    // Register reset values
    localparam logic        MODE_RST     = 1'b0;
    localparam logic [15:0] MIN_FRAG_RST = 16'd40;
    localparam logic [15:0] MAX_FRAG_RST = 16'd220;
    localparam logic [7:0]  SITE_RST     = 8'd90;   // C C G G
    localparam logic [2:0]  CUT_RST      = 3'd1;

    // Modes
    localparam logic MODE_FRAG = 1'b0;
    localparam logic MODE_CPG  = 1'b1;

    // Result kinds
    localparam logic KIND_FRAG = 1'b0;
    localparam logic KIND_CPG  = 1'b1;

    // Base codes
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;

    // Largest usable cut offset
    localparam logic [2:0] CUT_MAX = 3'd4;

    // History with all three slots invalid
    localparam logic [8:0] HIST_EMPTY = 9'h124;

    typedef struct packed {
        logic        mode;
        logic [15:0] min_frag;
        logic [15:0] max_frag;
        logic [7:0]  site_pattern;
        logic [2:0]  cut_offset;
    } rfs_cfg_t;

    typedef struct packed {
        logic [2:0] base;
        logic       end_of_sequence;
    } rfs_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] frag_start;
        logic [31:0] frag_stop;
        logic [15:0] cpg_count;
        logic [31:0] cpg_position;
        logic        last_of_run;
    } rfs_out_t;

endpackage

>>> rtl/restriction_fragment_scanner_unit.sv
// ============================================================================
// restriction_fragment_scanner_unit
// In-silico restriction digest of a DNA base stream, one base per item.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------
//  bases in  | push / full           | item   (base, end_of_sequence)
//  results   | pop / empty           | result (kind, start, stop, count,
//            |                       |         cpg_position, last_of_run)
//  config    | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
//  A base is taken every cycle while full is low; the front updates the
//  history, position, cut point and CpG count in that same cycle.
//  A result reaches the output through the queue, then the output register
//  where the size filter is applied, and can be popped from there.
//  Each item gives up to two results and the output hands out one per cycle
//  while pop is high, so a run of double-result items fills the queue.
//  Reset brings the control state and the configuration registers to their defaults.
//  A stalled output fills the four-entry job queue, then raises full.
//
module restriction_fragment_scanner_unit #(
    parameter int POS_WIDTH   = rfs_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = rfs_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // base items
    input  logic              push,
    output logic              full,
    input  rfs_pkg::rfs_in_t  item,
    // result items
    input  logic              pop,
    output logic              empty,
    output rfs_pkg::rfs_out_t result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int JOB_W = 2 * (2 + 2 * POS_WIDTH + COUNT_WIDTH);

    // Configuration registers
    logic        mode_reg,     mode_next;
    logic [15:0] min_frag_reg, min_frag_next;
    logic [15:0] max_frag_reg, max_frag_next;
    logic [7:0]  site_reg,     site_next;
    logic [2:0]  cut_reg,      cut_next;

    rfs_pkg::rfs_cfg_t cfg;

    logic [rfs_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    logic             q_push, q_pop, q_full, q_empty;
    logic [JOB_W-1:0] q_in, q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    assign cfg.mode         = mode_reg;
    assign cfg.min_frag     = min_frag_reg;
    assign cfg.max_frag     = max_frag_reg;
    assign cfg.site_pattern = site_reg;
    assign cfg.cut_offset   = cut_reg;

    // Register write decode
    always_comb
    begin
        mode_next     = mode_reg;
        min_frag_next = min_frag_reg;
        max_frag_next = max_frag_reg;
        site_next     = site_reg;
        cut_next      = cut_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rfs_pkg::REG_MODE:     mode_next     = pwdata[0];
                rfs_pkg::REG_MIN_FRAG: min_frag_next = pwdata[15:0];
                rfs_pkg::REG_MAX_FRAG: max_frag_next = pwdata[15:0];
                rfs_pkg::REG_SITE:     site_next     = pwdata[7:0];
                rfs_pkg::REG_CUT:      cut_next      = pwdata[2:0];
                default:               ;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_idx)
            rfs_pkg::REG_MODE:     prdata = 32'(mode_reg);
            rfs_pkg::REG_MIN_FRAG: prdata = 32'(min_frag_reg);
            rfs_pkg::REG_MAX_FRAG: prdata = 32'(max_frag_reg);
            rfs_pkg::REG_SITE:     prdata = 32'(site_reg);
            rfs_pkg::REG_CUT:      prdata = 32'(cut_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rfs_pkg::MODE_RST;
            min_frag_reg <= rfs_pkg::MIN_FRAG_RST;
            max_frag_reg <= rfs_pkg::MAX_FRAG_RST;
            site_reg     <= rfs_pkg::SITE_RST;
            cut_reg      <= rfs_pkg::CUT_RST;
        end
        else
        begin
            mode_reg     <= mode_next;
            min_frag_reg <= min_frag_next;
            max_frag_reg <= max_frag_next;
            site_reg     <= site_next;
            cut_reg      <= cut_next;
        end
    end

    // Front: classify each base and build candidate records
    rfs_front #(
        .POS_WIDTH   (POS_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .job    (q_in)
    );

    // Hold jobs so front and back stall independently
    rfs_queue #(
        .WIDTH (JOB_W),
        .DEPTH (rfs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: filter by size and hand out records
    rfs_back #(
        .POS_WIDTH   (POS_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full = q_full;

endmodule

>>> rtl/rfs_front.sv
// ============================================================================
// rfs_front
// Accepts bases, tracks history and counters, and builds candidate records.
// ============================================================================
module rfs_front #(
    parameter int POS_WIDTH   = rfs_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = rfs_pkg::COUNT_WIDTH_DEF,
    parameter int JOB_W       = 2 * (2 + 2 * POS_WIDTH + COUNT_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rfs_pkg::rfs_cfg_t cfg,
    input  logic              push,
    input  rfs_pkg::rfs_in_t  item,
    input  logic              q_full,
    output logic              q_push,
    output logic [JOB_W-1:0]  job
);

    localparam int P = POS_WIDTH;
    localparam int C = COUNT_WIDTH;

    logic [8:0]   hist_reg,  hist_next;
    logic [P-1:0] pos_reg,   pos_next;
    logic [P-1:0] cut_reg,   cut_next;
    logic [C-1:0] cnt_reg,   cnt_next;

    logic         accept;
    logic         bad;
    logic [2:0]   s0, s1, s2;
    logic         hist_full;
    logic         site;
    logic         cg;
    logic [2:0]   off;
    logic [P:0]   t_sum;
    logic [P:0]   stop_w;
    logic [P:0]   cut_w;
    logic [P-1:0] site_stop;
    logic [P-1:0] site_cut;
    logic [P-1:0] pos_upd;
    logic [P-1:0] cut_upd;
    logic [C-1:0] cnt_upd;
    logic [8:0]   hist_upd;
    logic         v0, v1, k0;
    logic [P-1:0] st0, sp0;

    assign accept = push && !q_full;

    always_comb
    begin
        bad       = item.base[2];
        s0        = hist_reg[2:0];
        s1        = hist_reg[5:3];
        s2        = hist_reg[8:6];
        hist_full = !s0[2] && !s1[2] && !s2[2];
        site      = !bad && (cfg.mode == rfs_pkg::MODE_FRAG) && hist_full &&
                    ({s2[1:0], s1[1:0], s0[1:0], item.base[1:0]} == cfg.site_pattern);
        cg        = !bad && (s0 == rfs_pkg::BASE_C) && (item.base == rfs_pkg::BASE_G);

        off       = (cfg.cut_offset > rfs_pkg::CUT_MAX) ? rfs_pkg::CUT_MAX : cfg.cut_offset;
        t_sum     = {1'b0, pos_reg} + (P+1)'(off);
        stop_w    = (t_sum >= (P+1)'(3)) ? t_sum - (P+1)'(3) : '0;
        cut_w     = (t_sum >= (P+1)'(3)) ? t_sum - (P+1)'(2) : (P+1)'(1);
        site_stop = stop_w[P] ? '1 : stop_w[P-1:0];
        site_cut  = cut_w[P]  ? '1 : cut_w[P-1:0];

        pos_upd   = (&pos_reg) ? pos_reg : pos_reg + P'(1);
        cut_upd   = site ? site_cut : cut_reg;
        if (site)
            cnt_upd = '0;
        else if (cg && (cfg.mode == rfs_pkg::MODE_FRAG) && !(&cnt_reg))
            cnt_upd = cnt_reg + C'(1);
        else
            cnt_upd = cnt_reg;
        hist_upd  = bad ? rfs_pkg::HIST_EMPTY : {hist_reg[5:0], item.base};

        // Slot 0: site cut or CpG position; slot 1: end-of-sequence fragment
        v0  = site || (cg && (cfg.mode == rfs_pkg::MODE_CPG));
        k0  = site ? rfs_pkg::KIND_FRAG : rfs_pkg::KIND_CPG;
        st0 = cut_reg;
        sp0 = site ? site_stop : pos_reg;
        v1  = item.end_of_sequence && (cfg.mode == rfs_pkg::MODE_FRAG);
    end

    assign job    = {v1, rfs_pkg::KIND_FRAG, cut_upd, pos_upd, cnt_upd,
                     v0, k0, st0, sp0, cnt_reg};
    assign q_push = accept && (v0 || v1);

    always_comb
    begin
        hist_next = hist_reg;
        pos_next  = pos_reg;
        cut_next  = cut_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (item.end_of_sequence)
            begin
                hist_next = rfs_pkg::HIST_EMPTY;
                pos_next  = '0;
                cut_next  = P'(1);
                cnt_next  = '0;
            end
            else
            begin
                hist_next = hist_upd;
                pos_next  = pos_upd;
                cut_next  = cut_upd;
                cnt_next  = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= rfs_pkg::HIST_EMPTY;
            pos_reg  <= '0;
            cut_reg  <= P'(1);
            cnt_reg  <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            pos_reg  <= pos_next;
            cut_reg  <= cut_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> rtl/rfs_queue.sv
// ============================================================================
// rfs_queue
// Small first-in first-out queue of jobs between front and back.
// ============================================================================
module rfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rfs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/rfs_back.sv
// ============================================================================
// rfs_back
// Applies the size filter to queued jobs and hands out records one at a time.
// ============================================================================
module rfs_back #(
    parameter int POS_WIDTH   = rfs_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = rfs_pkg::COUNT_WIDTH_DEF,
    parameter int JOB_W       = 2 * (2 + 2 * POS_WIDTH + COUNT_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rfs_pkg::rfs_cfg_t cfg,
    input  logic [JOB_W-1:0]  q_head,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output rfs_pkg::rfs_out_t result
);

    localparam int P      = POS_WIDTH;
    localparam int C      = COUNT_WIDTH;
    localparam int SLOT_W = 2 + 2 * P + C;

    logic [JOB_W-1:0] job_reg,  job_next;
    logic [1:0]       pass_reg, pass_next;

    logic [SLOT_W-1:0] h0, h1, j0, j1, cur;
    logic [1:0]        head_pass;
    logic              sel;
    logic              last;
    logic              take;
    logic              load_ok;

    function automatic logic frag_ok(input logic [P-1:0] start, input logic [P-1:0] stop,
                                     input logic [15:0] lo, input logic [15:0] hi);
        logic [P:0] end1;
        logic [P:0] len;
        end1 = {1'b0, stop} + (P+1)'(1);
        len  = (end1 >= {1'b0, start}) ? end1 - {1'b0, start} : '0;
        if (lo != '0 && hi != '0)
            return (len >= (P+1)'(lo)) && (len <= (P+1)'(hi));
        return 1'b1;
    endfunction

    // Slot layout, msb first: valid, kind, start, stop, count
    always_comb
    begin
        h0 = q_head[SLOT_W-1:0];
        h1 = q_head[JOB_W-1:SLOT_W];
        j0 = job_reg[SLOT_W-1:0];
        j1 = job_reg[JOB_W-1:SLOT_W];

        head_pass[0] = h0[SLOT_W-1] &&
                       ((h0[SLOT_W-2] == rfs_pkg::KIND_CPG) ||
                        frag_ok(h0[C+2*P-1:C+P], h0[C+P-1:C], cfg.min_frag, cfg.max_frag));
        head_pass[1] = h1[SLOT_W-1] &&
                       frag_ok(h1[C+2*P-1:C+P], h1[C+P-1:C], cfg.min_frag, cfg.max_frag);

        sel     = !pass_reg[0];
        cur     = sel ? j1 : j0;
        last    = sel || !pass_reg[1];
        empty   = !(|pass_reg);
        take    = pop && !empty;
        load_ok = empty || (take && last);
        q_pop   = load_ok && !q_empty;

        job_next  = job_reg;
        pass_next = pass_reg;
        if (q_pop)
        begin
            job_next  = q_head;
            pass_next = head_pass;
        end
        else if (take)
        begin
            // advance to the second record, or drop the finished job
            pass_next = last ? 2'b00 : 2'b10;
        end
    end

    always_comb
    begin
        result.kind         = cur[SLOT_W-2];
        result.last_of_run  = last;
        if (cur[SLOT_W-2] == rfs_pkg::KIND_CPG)
        begin
            result.frag_start   = '0;
            result.frag_stop    = '0;
            result.cpg_count    = '0;
            result.cpg_position = 32'(cur[C+P-1:C]);
        end
        else
        begin
            result.frag_start   = 32'(cur[C+2*P-1:C+P]);
            result.frag_stop    = 32'(cur[C+P-1:C]);
            result.cpg_count    = 16'(cur[C-1:0]);
            result.cpg_position = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pass_reg <= '0;
        else
            pass_reg <= pass_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule
